>>> rtl/core/ecfb_pkg.sv
// Shared constants, types and helpers for the escaped command frame builder.
`default_nettype none

package ecfb_pkg;

   localparam logic [7:0] FLAG_START = 8'h12;
   localparam logic [7:0] FLAG_END   = 8'h13;
   localparam logic [7:0] ESC_BYTE   = 8'h7D;

   localparam int NUM_CODES     = 5;
   localparam int PAYLOAD_BYTES = 5;

   localparam logic [2:0] ACT_TRIGGER_INPUT  = 3'd0;
   localparam logic [2:0] ACT_TRIGGER_PARAM  = 3'd1;
   localparam logic [2:0] ACT_QUERY_INPUT    = 3'd2;
   localparam logic [2:0] ACT_QUERY_PARAM    = 3'd3;
   localparam logic [2:0] ACT_DUMP_OPERATORS = 3'd4;

   localparam logic [2:0] REG_CODE_TRIGGER_INPUT  = 3'd0;
   localparam logic [2:0] REG_CODE_TRIGGER_PARAM  = 3'd1;
   localparam logic [2:0] REG_CODE_QUERY_INPUT    = 3'd2;
   localparam logic [2:0] REG_CODE_QUERY_PARAM    = 3'd3;
   localparam logic [2:0] REG_CODE_DUMP_OPERATORS = 3'd4;

   typedef logic [NUM_CODES-1:0][7:0]     code_array_type;
   typedef logic [PAYLOAD_BYTES-1:0][7:0] payload_type;

   localparam code_array_type CODE_RESET = {8'd4, 8'd3, 8'd2, 8'd1, 8'd0};

   function automatic logic needs_escape(input logic [7:0] b);
      needs_escape = (b == FLAG_START) || (b == FLAG_END) || (b == ESC_BYTE);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/ecfb_csr.sv
// Command code register file written through the configuration channel.
`default_nettype none

module ecfb_csr
   import ecfb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_valid,
   input  wire logic [2:0]     csr_index,
   input  wire logic [7:0]     csr_data,
   output code_array_type      codes
);

   code_array_type codes_ff;
   code_array_type codes_in;

   always_comb begin
      codes_in = codes_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_CODE_TRIGGER_INPUT:  codes_in[0] = csr_data;
            REG_CODE_TRIGGER_PARAM:  codes_in[1] = csr_data;
            REG_CODE_QUERY_INPUT:    codes_in[2] = csr_data;
            REG_CODE_QUERY_PARAM:    codes_in[3] = csr_data;
            REG_CODE_DUMP_OPERATORS: codes_in[4] = csr_data;
            default:                 codes_in = codes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff <= CODE_RESET;
      end else begin
         codes_ff <= codes_in;
      end
   end

   assign codes = codes_ff;

endmodule

`default_nettype wire

>>> rtl/core/escaped_command_frame_builder.sv
// Top level of the escaped command frame builder: command capture and byte serializer.
//
// Usage: each beat on the req_ channel is one command (action, index, value).
// The block answers it on the rsp_ channel with one beat per frame byte:
// start flag, command code, big-endian index and value where the command
// carries them, and the end flag, which is marked by rsp_last. Any payload
// byte equal to a flag or to the escape byte is preceded by the escape byte.
// Actions 5 to 7 are accepted and produce no beats.
// A taken command is registered into the START state, which then loads the
// start flag into the output register. A frame has 3 to 12 bytes, and the
// next command is taken in the cycle the end flag is loaded, so frames follow
// one another without a gap. The output gives one byte per cycle unless stalled.
// When the receiver stalls, the output register holds its byte and the
// serializer waits; req_ready stays low until the current frame's end flag
// moves into the output register.
// The csr_ channel writes the five command code registers, is always ready, ignores
// indexes 5 and above. The user must change codes only while idle; the block does not
// enforce it. Reset clears the serializer, drops any pending byte, restores the codes.
`default_nettype none

module escaped_command_frame_builder
   import ecfb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_action,
   input  wire logic [15:0]        req_index,
   input  wire logic signed [15:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [7:0]         csr_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_BODY  = 2'd2;
   localparam logic [1:0] ST_END   = 2'd3;

   code_array_type codes;

   logic [1:0]  state_ff, state_in;
   payload_type payload_ff, payload_in;
   logic [2:0]  remain_ff, remain_in;
   logic        esc_ff, esc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        out_free;
   logic        req_take;
   logic [7:0]  head;

   ecfb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .codes     (codes)
   );

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_END) && out_free);
   assign req_take  = req_valid && req_ready;
   assign head      = payload_ff[0];

   always_comb begin
      state_in     = state_ff;
      payload_in   = payload_ff;
      remain_in    = remain_ff;
      esc_in       = esc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         unique case (state_ff)
            ST_IDLE: begin
               rsp_valid_in = 1'b0;
            end
            ST_START: begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = FLAG_START;
               rsp_last_in  = 1'b0;
               state_in     = ST_BODY;
            end
            ST_BODY: begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               if (needs_escape(head) && !esc_ff) begin
                  rsp_byte_in = ESC_BYTE;
                  esc_in      = 1'b1;
               end else begin
                  rsp_byte_in = head;
                  esc_in      = 1'b0;
                  payload_in  = payload_ff >> 8;
                  remain_in   = remain_ff - 3'd1;
                  if (remain_ff == 3'd1) begin
                     state_in = ST_END;
                  end
               end
            end
            ST_END: begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = FLAG_END;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
      if (req_take) begin
         payload_in[1] = req_index[15:8];
         payload_in[2] = req_index[7:0];
         payload_in[3] = req_value[15:8];
         payload_in[4] = req_value[7:0];
         esc_in        = 1'b0;
         state_in      = ST_START;
         case (req_action)
            ACT_TRIGGER_INPUT: begin
               payload_in[0] = codes[0];
               remain_in     = 3'd5;
            end
            ACT_TRIGGER_PARAM: begin
               payload_in[0] = codes[1];
               remain_in     = 3'd5;
            end
            ACT_QUERY_INPUT: begin
               payload_in[0] = codes[2];
               remain_in     = 3'd3;
            end
            ACT_QUERY_PARAM: begin
               payload_in[0] = codes[3];
               remain_in     = 3'd3;
            end
            ACT_DUMP_OPERATORS: begin
               payload_in[0] = codes[4];
               remain_in     = 3'd1;
            end
            default: begin
               payload_in[0] = 8'h00;
               remain_in     = remain_ff;
               state_in      = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         esc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         esc_ff       <= esc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff  <= payload_in;
      remain_ff   <= remain_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire
